>>> design/sha_ms_pkg.sv
// shared types, codes and sigma functions for the sha-256 message schedule unit
`default_nettype none

package sha_ms_pkg;

  localparam int WordBits     = 32;
  localparam int GroupWords   = 4;
  localparam int WindowGroups = 4;
  localparam int WindowWords  = GroupWords * WindowGroups;

  typedef logic [WordBits-1:0] word_t;
  typedef word_t [GroupWords-1:0] group_t;
  typedef group_t [WindowGroups-1:0] window_t;

  // transaction kind codes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_EXPAND = 1'b1;

  typedef struct packed {
    logic  mode;
    word_t msg_word_0;
    word_t msg_word_1;
    word_t msg_word_2;
    word_t msg_word_3;
    word_t round_const_0;
    word_t round_const_1;
    word_t round_const_2;
    word_t round_const_3;
  } in_t;

  typedef struct packed {
    word_t sched_word_0;
    word_t sched_word_1;
    word_t sched_word_2;
    word_t sched_word_3;
    word_t word_plus_k_0;
    word_t word_plus_k_1;
    word_t word_plus_k_2;
    word_t word_plus_k_3;
  } out_t;

  function automatic word_t small_sigma0(input word_t v);
    return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t v);
    return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'b0, v[31:10]};
  endfunction

endpackage

`default_nettype wire

>>> design/sha_ms_cell.sv
// one cell: four schedule words, shifted in from the next younger cell or new words
`default_nettype none

module sha_ms_cell
  import sha_ms_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   shift_en,
  input  wire group_t d_in,
  output group_t      q
);

  group_t words_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      words_r <= d_in;
    end
  end

  assign q = words_r;

endmodule

`default_nettype wire

>>> design/sha_ms_expand.sv
// recurrence logic: four new schedule words from the 16-word window
`default_nettype none

module sha_ms_expand
  import sha_ms_pkg::*;
(
  input  wire window_t window,
  output group_t       fresh
);

  word_t ext [WindowWords+GroupWords];

  always_comb begin
    for (int g = 0; g < WindowGroups; g++) begin
      for (int k = 0; k < GroupWords; k++) begin
        ext[g*GroupWords+k] = window[g][k];
      end
    end
    // words 2 and 3 chain on words 0 and 1 of this step
    for (int j = 0; j < GroupWords; j++) begin
      ext[WindowWords+j] = small_sigma1(ext[WindowWords+j-2]) + ext[WindowWords+j-7]
                         + small_sigma0(ext[j+1]) + ext[j];
    end
    for (int j = 0; j < GroupWords; j++) begin
      fresh[j] = ext[WindowWords+j];
    end
  end

endmodule

`default_nettype wire

>>> design/sha256_message_schedule_x4_unit.sv
// top level of the sha-256 message schedule unit, four words per transaction
//
// usage:
//   in_valid/in_ready/in_data carry one transaction per cycle while in_ready is high. mode load shifts
//   msg_word_0..3 into the 16-word window (word 0 oldest) and gives no result;
//   mode expand computes four new schedule words, shifts them into the window
//   and gives one result on out_valid/out_ready/out_data.
//   load all 16 message words (four load transactions) before the first expand;
//   window contents are undefined after reset until written.
// results: each expand result is registered before it is presented on out_data.
// throughput: one transaction per cycle while in_ready is high; the window is
//   a row of four cells that shifts by one cell per accepted transaction, and
//   the expand logic is a combinational sigma/add chain reading the window directly.
// stalls: the result register is backed by a one-entry skid register, so a
//   transaction is still taken while a result waits; in_ready drops only
//   when both are full. no result is lost or repeated.
// reset: synchronous active-low rst_n clears both result valids; window data
//   is not reset.
`default_nettype none

module sha256_message_schedule_x4_unit
  import sha_ms_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic    in_fire;
  logic    push;
  logic    pop;
  window_t window;
  group_t  fresh_calc;
  group_t  fresh;
  out_t    result;

  logic out_valid_r;
  logic skid_valid_r;
  out_t out_data_r;
  out_t skid_data_r;

  // only a full skid register holds off the input side
  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign push     = in_fire && (in_data.mode == MODE_EXPAND);
  assign pop      = out_valid_r && out_ready;

  // window: cell 0 holds the oldest four words, cell 3 the newest
  for (genvar g = 0; g < WindowGroups; g++) begin : g_cell
    group_t d_in;
    if (g == WindowGroups - 1) begin : g_tail
      assign d_in = fresh;
    end else begin : g_link
      assign d_in = window[g+1];
    end
    sha_ms_cell u_cell (
      .clk      (clk),
      .shift_en (in_fire),
      .d_in     (d_in),
      .q        (window[g])
    );
  end

  sha_ms_expand u_expand (
    .window (window),
    .fresh  (fresh_calc)
  );

  // words entering the window: message words on load, new words on expand
  always_comb begin
    unique case (in_data.mode)
      MODE_EXPAND: fresh = fresh_calc;
      default: begin
        fresh[0] = in_data.msg_word_0;
        fresh[1] = in_data.msg_word_1;
        fresh[2] = in_data.msg_word_2;
        fresh[3] = in_data.msg_word_3;
      end
    endcase
  end

  always_comb begin
    result.sched_word_0  = fresh_calc[0];
    result.sched_word_1  = fresh_calc[1];
    result.sched_word_2  = fresh_calc[2];
    result.sched_word_3  = fresh_calc[3];
    result.word_plus_k_0 = fresh_calc[0] + in_data.round_const_0;
    result.word_plus_k_1 = fresh_calc[1] + in_data.round_const_1;
    result.word_plus_k_2 = fresh_calc[2] + in_data.round_const_2;
    result.word_plus_k_3 = fresh_calc[3] + in_data.round_const_3;
  end

  // result register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        // drain skid first; input is held off meanwhile
        out_data_r   <= skid_data_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
        if (push) begin
          out_data_r <= result;
        end
      end
    end else if (push) begin
      skid_data_r  <= result;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // skid holds data only behind a waiting result
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while result register empty");

  // an expand taken while the result stalls lands in the skid register
  a_stall_to_skid : assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("expand result dropped during output stall");

  // a load into an empty output side creates no result
  a_load_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.mode == MODE_LOAD) && !out_valid_r) |=> !out_valid_r)
    else $error("load transaction produced a result");

endmodule

`default_nettype wire
